// ===== sv/stbs_pkg.sv =====
`default_nettype none
package stbs_pkg;
    localparam int TableDepth   = 256;
    localparam int IdxW         = 8;
    localparam int CntW         = 9;
    localparam int TimeW        = 32;
    localparam int FracW        = 16;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOCATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [IdxW-1:0]        entry_index;
        logic signed [TimeW-1:0] time_value_in;
    } stbs_in_t;

    typedef struct packed {
        logic                   ok;
        logic [IdxW-1:0]        lower_index;
        logic [IdxW-1:0]        upper_index;
        logic [FracW-1:0]       fraction;
        logic                   exact_hit;
        logic signed [TimeW-1:0] time_value_out;
    } stbs_out_t;

    // signed order mapped to unsigned order
    function automatic logic [TimeW-1:0] key_of(input logic [TimeW-1:0] raw);
        key_of = raw ^ {1'b1, {(TimeW-1){1'b0}}};
    endfunction
endpackage
`default_nettype wire

// ===== sv/stbs_divider.sv =====
`default_nettype none
// restoring modular divider, one quotient bit per cycle
module stbs_divider
    import stbs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             mode_est,
    input  wire logic [TimeW-1:0] num,
    input  wire logic [TimeW-1:0] span,
    input  wire logic [IdxW-1:0]  mult,
    output logic                  done,
    output logic [TimeW-1:0]      quot
);
    logic             busy_reg, busy_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             est_reg, est_next;
    logic [TimeW-1:0] r_reg, r_next, q_reg, q_next, num_reg, span_reg;
    logic [IdxW-1:0]  m_reg;
    logic [TimeW:0]   s1, s2;
    logic [TimeW-1:0] r1;
    logic             c1, c2;

    always_comb begin
        s1 = {1'b0, r_reg} + {1'b0, r_reg};
        c1 = s1 >= {1'b0, span_reg};
        r1 = c1 ? TimeW'(s1 - {1'b0, span_reg}) : s1[TimeW-1:0];
        s2 = {1'b0, r1} + {1'b0, num_reg};
        c2 = est_reg && m_reg[cnt_reg[2:0]] && cnt_reg < 6'd8 && s2 >= {1'b0, span_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        est_next  = est_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        done      = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            est_next  = mode_est;
            r_next    = mode_est ? '0 : num;
            q_next    = '0;
            cnt_next  = mode_est ? 6'd8 : 6'(FracW - 1);
        end else if (busy_reg) begin
            if (est_reg && cnt_reg == 6'd8) begin
                // final rounding step
                q_next = q_reg + TimeW'(c1);
                done = 1'b1;
                busy_next = 1'b0;
            end else begin
                q_next = TimeW'({q_reg, 1'b0}) + TimeW'(c1) + TimeW'(c2);
                if (est_reg && m_reg[cnt_reg[2:0]])
                    r_next = c2 ? TimeW'(s2 - {1'b0, span_reg}) : s2[TimeW-1:0];
                else
                    r_next = r1;
                if (cnt_reg == 6'd0) begin
                    if (est_reg) cnt_next = 6'd8;
                    else begin
                        done = 1'b1;
                        busy_next = 1'b0;
                    end
                end else cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    // estimate: 8 multiplier bits msb first, then rounding; counter starts at 7
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= (start && mode_est) ? 6'd7 : cnt_next;
        est_reg <= est_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        if (start) begin
            num_reg  <= num;
            span_reg <= span;
            m_reg    <= mult;
        end
    end
    assign quot = q_next;
endmodule
`default_nettype wire

// ===== sv/sorted_table_bracket_search_core.sv =====
`default_nettype none
// sorted time table with bracket search. commands are write, read and locate on a
// 256-entry single-port table memory (one access per cycle, registered read data).
// a write inside the count gives its result in the cycle after acceptance; a write
// that grows the table writes its time to every entry from the old count up to its
// index, and a read waits in ST_RDW for the read data. locate reads the first and
// last entries (a time outside the table is answered from these alone), runs the
// interpolation estimate in the shared serial divider unless both are equal, then
// bisects with neighbour checks at 2 memory reads per probe (up to about log2 of the
// count plus one probes), reads both bracket entries and ends with a 16-bit fraction
// division unless the fraction is zero or full. one transaction in flight; a new
// transaction is taken only once the previous result has left or leaves in the same cycle.
module sorted_table_bracket_search_core
    import stbs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire stbs_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output stbs_out_t      m_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_RD0   = 4'd2;
    localparam logic [3:0] ST_EST   = 4'd4;
    localparam logic [3:0] ST_PRB   = 4'd5;
    localparam logic [3:0] ST_PRBW  = 4'd6;
    localparam logic [3:0] ST_NBW   = 4'd7;
    localparam logic [3:0] ST_BLO   = 4'd8;
    localparam logic [3:0] ST_BHI   = 4'd9;
    localparam logic [3:0] ST_FRAC  = 4'd10;
    localparam logic [3:0] ST_RDW   = 4'd12;

    // table memory, one port
    logic [TimeW-1:0] mem [TableDepth];
    logic [TimeW-1:0] rdata_reg;
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [TimeW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    logic [3:0]       state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    stbs_in_t         req_reg;
    logic [IdxW-1:0]  fill_reg, fill_next;
    logic [TimeW-1:0] t_reg, first_reg, first_next;
    logic [TimeW-1:0] tl_reg, tl_next;
    logic [IdxW-1:0]  a_reg, a_next, lo_reg, lo_next, hi_reg, hi_next;
    logic             nbdir_reg, nbdir_next;
    logic             est_wait_reg, est_wait_next;
    stbs_out_t        res_reg, res_next;
    logic             mv_reg, mv_next;

    logic             div_start, div_est, div_done;
    logic [TimeW-1:0] div_num, div_span, div_q;
    logic [IdxW-1:0]  nm1;
    logic [TimeW-1:0] key_rd;
    logic [IdxW-1:0]  stepv;

    assign nm1    = IdxW'(count_reg - CntW'(1));
    assign key_rd = key_of(rdata_reg);
    assign stepv  = IdxW'((hi_reg - lo_reg) >> 1);

    stbs_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .mode_est(div_est),
        .num(div_num), .span(div_span), .mult(nm1), .done(div_done), .quot(div_q)
    );

    assign s_ready = (state_reg == ST_IDLE) && !(mv_reg && !m_ready);
    assign m_valid = mv_reg;
    assign m_data  = res_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        first_next    = first_reg;
        tl_next       = tl_reg;
        a_next        = a_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        nbdir_next    = nbdir_reg;
        est_wait_next = est_wait_reg;
        res_next      = res_reg;
        mv_next       = mv_reg && !m_ready;
        we            = 1'b0;
        addr          = a_reg;
        wdata         = req_reg.time_value_in;
        div_start     = 1'b0;
        div_est       = 1'b0;
        div_num       = '0;
        div_span      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    res_next = '0;
                    unique case (s_data.cmd)
                        CMD_WRITE: begin
                            res_next.ok = 1'b1;
                            if (CntW'(s_data.entry_index) >= count_reg) begin
                                fill_next  = IdxW'(count_reg);
                                state_next = ST_FILL;
                            end else begin
                                we = 1'b1;
                                addr = s_data.entry_index;
                                wdata = s_data.time_value_in;
                                mv_next = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            addr = s_data.entry_index;
                            if (CntW'(s_data.entry_index) < count_reg) state_next = ST_RDW;
                            else mv_next = 1'b1;
                        end
                        CMD_LOCATE: begin
                            if (count_reg == '0) mv_next = 1'b1;
                            else begin
                                addr = '0;
                                state_next = ST_RD0;
                            end
                        end
                        default: mv_next = 1'b1;
                    endcase
                end
            end
            ST_FILL: begin
                we = 1'b1;
                addr = fill_reg;
                fill_next = fill_reg + IdxW'(1);
                if (fill_reg == req_reg.entry_index) begin
                    count_next = CntW'(req_reg.entry_index) + CntW'(1);
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDW: begin
                res_next.ok = 1'b1;
                res_next.time_value_out = rdata_reg;
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD0: begin
                // first entry is on the read port, fetch the last one
                first_next = key_rd;
                addr = nm1;
                state_next = ST_EST;
            end
            ST_EST: begin
                lo_next = '0;
                hi_next = nm1;
                if (t_reg < first_reg) begin
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (t_reg > key_rd) begin
                    res_next.lower_index = nm1;
                    res_next.upper_index = nm1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (key_rd > first_reg) begin
                    div_start = 1'b1;
                    div_est = 1'b1;
                    div_num = t_reg - first_reg;
                    div_span = key_rd - first_reg;
                    est_wait_next = 1'b1;
                    state_next = ST_PRB;
                end else begin
                    a_next = '0;
                    est_wait_next = 1'b0;
                    state_next = ST_PRB;
                end
            end
            ST_PRB: begin
                // wait for estimate if running, then issue probe read
                if (est_wait_reg) begin
                    if (div_done) begin
                        a_next = (div_q > TimeW'(nm1)) ? nm1 : IdxW'(div_q);
                        est_wait_next = 1'b0;
                    end
                end else begin
                    addr = a_reg;
                    state_next = ST_PRBW;
                end
            end
            ST_PRBW: begin
                if (key_rd > t_reg) begin
                    hi_next = a_reg;
                    if (a_reg == '0) begin
                        lo_next = '0;
                        state_next = ST_BLO;
                    end else begin
                        addr = a_reg - IdxW'(1);
                        nbdir_next = 1'b0;
                        state_next = ST_NBW;
                    end
                end else if (key_rd < t_reg) begin
                    lo_next = a_reg;
                    if (a_reg >= nm1) begin
                        hi_next = a_reg;
                        state_next = ST_BLO;
                    end else begin
                        addr = a_reg + IdxW'(1);
                        nbdir_next = 1'b1;
                        state_next = ST_NBW;
                    end
                end else begin
                    lo_next = a_reg;
                    hi_next = a_reg;
                    state_next = ST_BLO;
                end
            end
            ST_NBW: begin
                if (!nbdir_reg && key_rd < t_reg) begin
                    lo_next = a_reg - IdxW'(1);
                    state_next = ST_BLO;
                end else if (nbdir_reg && key_rd > t_reg) begin
                    hi_next = a_reg + IdxW'(1);
                    state_next = ST_BLO;
                end else if (hi_reg <= lo_reg || stepv == '0) begin
                    state_next = ST_BLO;
                end else begin
                    a_next = lo_reg + stepv;
                    state_next = ST_PRB;
                end
            end
            ST_BLO: begin
                addr = lo_reg;
                state_next = ST_BHI;
            end
            ST_BHI: begin
                addr = hi_reg;
                tl_next = key_rd;
                state_next = ST_FRAC;
                a_next = '0;
            end
            ST_FRAC: begin
                if (a_reg == '0) begin
                    a_next = 8'd1;
                    res_next.ok = 1'b1;
                    res_next.lower_index = lo_reg;
                    res_next.upper_index = hi_reg;
                    if (!(key_rd > tl_reg && t_reg > tl_reg)) begin
                        res_next.exact_hit = 1'b1;
                        mv_next = 1'b1;
                        state_next = ST_IDLE;
                    end else if (t_reg - tl_reg >= key_rd - tl_reg) begin
                        res_next.fraction = '1;
                        mv_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        div_start = 1'b1;
                        div_num = t_reg - tl_reg;
                        div_span = key_rd - tl_reg;
                    end
                end else if (div_done) begin
                    res_next.fraction = div_q[FracW-1:0];
                    res_next.exact_hit = (div_q[FracW-1:0] == '0);
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            mv_reg       <= 1'b0;
            est_wait_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            mv_reg       <= mv_next;
            est_wait_reg <= est_wait_next;
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
            t_reg   <= key_of(s_data.time_value_in);
        end
        fill_reg  <= fill_next;
        first_reg <= first_next;
        tl_reg    <= tl_next;
        a_reg     <= a_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        nbdir_reg <= nbdir_next;
        res_reg   <= res_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(TableDepth)) else $error("count overflow");
    a_bracket_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ok && req_reg.cmd == CMD_LOCATE)
        |-> m_data.lower_index <= m_data.upper_index) else $error("bracket order");
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.exact_hit) |-> m_data.ok) else $error("hit without ok");
`endif
endmodule
`default_nettype wire
